FILE: design/fac_pkg.sv
`timescale 1ns / 1ps
package fac_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [2:0] {
		REG_HIGH_POWER  = 3'd0,
		REG_MID_POWER   = 3'd1,
		REG_FIRST_ESC   = 3'd2,
		REG_SECOND_ESC  = 3'd3,
		REG_OVERHEAT    = 3'd4,
		REG_SENSOR_FAIL = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] high_power_limit;
		logic [31:0] mid_power_limit;
		logic [31:0] first_escalation_ms;
		logic [31:0] second_escalation_ms;
		logic [8:0]  overheat_celsius;
		logic [8:0]  sensor_fail_celsius;
	} cfg_t;

	typedef struct packed {
		logic [8:0] celsius;
		logic [2:0] level;
		logic       overheat;
		logic       sensor_fail;
	} temp_res_t;

	localparam logic [31:0] HIGH_POWER_RST  = 32'd100000000;
	localparam logic [31:0] MID_POWER_RST   = 32'd50000000;
	localparam logic [31:0] FIRST_ESC_RST   = 32'd30000;
	localparam logic [31:0] SECOND_ESC_RST  = 32'd90000;
	localparam logic [8:0]  OVERHEAT_RST    = 9'd80;
	localparam logic [8:0]  SENSOR_FAIL_RST = 9'd140;

	localparam logic [6:0] TEMP_SCALE_NUM = 7'd125;

	localparam logic [8:0] TEMP_STEP_1 = 9'd35;
	localparam logic [8:0] TEMP_STEP_2 = 9'd45;
	localparam logic [8:0] TEMP_STEP_3 = 9'd55;
	localparam logic [8:0] TEMP_STEP_4 = 9'd65;

	localparam logic [2:0] LEVEL_0 = 3'd0;
	localparam logic [2:0] LEVEL_1 = 3'd1;
	localparam logic [2:0] LEVEL_2 = 3'd2;
	localparam logic [2:0] LEVEL_3 = 3'd3;
	localparam logic [2:0] LEVEL_4 = 3'd4;

	function automatic logic [7:0] duty_of(input logic [2:0] lvl);
		logic [7:0] d;
		case (lvl)
			LEVEL_1: d = 8'd80;
			LEVEL_2: d = 8'd125;
			LEVEL_3: d = 8'd190;
			LEVEL_4: d = 8'd255;
			default: d = 8'd0;
		endcase
		return d;
	endfunction

endpackage

FILE: design/fac_regs.sv
`timescale 1ns / 1ps
module fac_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fac_pkg::ADDR_W-1:0]  paddr,
	input  logic [fac_pkg::DATA_W-1:0]  pwdata,
	output logic [fac_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output fac_pkg::cfg_t               cfg
);
	import fac_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_power_limit     <= HIGH_POWER_RST;
			cfg_q.mid_power_limit      <= MID_POWER_RST;
			cfg_q.first_escalation_ms  <= FIRST_ESC_RST;
			cfg_q.second_escalation_ms <= SECOND_ESC_RST;
			cfg_q.overheat_celsius     <= OVERHEAT_RST;
			cfg_q.sensor_fail_celsius  <= SENSOR_FAIL_RST;
		end else if (wr_en) begin
			case (idx)
				REG_HIGH_POWER:  cfg_q.high_power_limit     <= pwdata;
				REG_MID_POWER:   cfg_q.mid_power_limit      <= pwdata;
				REG_FIRST_ESC:   cfg_q.first_escalation_ms  <= pwdata;
				REG_SECOND_ESC:  cfg_q.second_escalation_ms <= pwdata;
				REG_OVERHEAT:    cfg_q.overheat_celsius     <= pwdata[8:0];
				REG_SENSOR_FAIL: cfg_q.sensor_fail_celsius  <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_HIGH_POWER:  prdata = cfg_q.high_power_limit;
			REG_MID_POWER:   prdata = cfg_q.mid_power_limit;
			REG_FIRST_ESC:   prdata = cfg_q.first_escalation_ms;
			REG_SECOND_ESC:  prdata = cfg_q.second_escalation_ms;
			REG_OVERHEAT:    prdata = {23'd0, cfg_q.overheat_celsius};
			REG_SENSOR_FAIL: prdata = {23'd0, cfg_q.sensor_fail_celsius};
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: design/fac_temp.sv
`timescale 1ns / 1ps
module fac_temp (
	input  logic [9:0]          temp_adc,
	input  fac_pkg::cfg_t       cfg,
	output fac_pkg::temp_res_t  res
);
	import fac_pkg::*;

	logic [16:0] scaled;
	logic [8:0]  celsius;
	logic        fail;

	// 0.48828125 = 125/256
	assign scaled  = {7'd0, temp_adc} * {10'd0, TEMP_SCALE_NUM};
	assign celsius = scaled[16:8];
	assign fail    = celsius >= cfg.sensor_fail_celsius;

	always_comb begin
		res.celsius     = celsius;
		res.sensor_fail = fail;
		res.overheat    = (celsius >= cfg.overheat_celsius) | fail;
		if (celsius >= TEMP_STEP_4)
			res.level = LEVEL_4;
		else if (celsius >= TEMP_STEP_3)
			res.level = LEVEL_3;
		else if (celsius >= TEMP_STEP_2)
			res.level = LEVEL_2;
		else if (celsius >= TEMP_STEP_1)
			res.level = LEVEL_1;
		else
			res.level = LEVEL_0;
	end

endmodule

FILE: design/fac_power.sv
`timescale 1ns / 1ps
module fac_power (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          update,
	input  logic [31:0]   power,
	input  logic [31:0]   now_ms,
	input  fac_pkg::cfg_t cfg,
	output logic [2:0]    level
);
	import fac_pkg::*;

	logic        active_q;
	logic [31:0] start_q;
	logic        is_high;
	logic        is_mid;
	logic [31:0] start_eff;
	logic [31:0] elapsed;

	assign is_high   = power >= cfg.high_power_limit;
	assign is_mid    = power >= cfg.mid_power_limit;
	// timer restarts only on entry from below the middle band into it
	assign start_eff = active_q ? start_q : now_ms;
	assign elapsed   = now_ms - start_eff;

	always_comb begin
		if (is_high)
			level = LEVEL_3;
		else if (!is_mid)
			level = LEVEL_0;
		else if (elapsed >= cfg.second_escalation_ms)
			level = LEVEL_2;
		else if (elapsed >= cfg.first_escalation_ms)
			level = LEVEL_1;
		else
			level = LEVEL_0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			start_q  <= '0;
		end else if (update) begin
			if (is_high) begin
				active_q <= 1'b1;
			end else if (is_mid) begin
				active_q <= 1'b1;
				start_q  <= start_eff;
			end else begin
				active_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/fan_aggression_controller_unit.sv
`timescale 1ns / 1ps
// channel  dir  handshake                  payload
// s_*      in   s_tvalid/s_tready          sample word, 80-bit tdata
// m_*      out  m_tvalid/m_tready          result word, 24-bit tdata
// apb      in   psel/penable/pwrite/pready limits and delays, 32-bit data
//
// one word per cycle while m_tready stays high, via stage 1 and stage 2 registers
// stage 1 registers the sample and the voltage times current product
// stage 2 compares, runs the escalation timer and registers the result
// a stalled result holds in stage 2 while stage 1 still takes one more word
// arst_n clears valid bits, timer state and loads register defaults
module fan_aggression_controller_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// temp_adc[9:0], voltage_mv[25:10], current_ma[41:26], now_ms[73:42], zero pad
	input  logic [79:0]                s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// fan_duty[7:0], fan_level[10:8], temp_celsius[19:11], overheat_alarm[20],
	// sensor_fail_alarm[21], zero pad
	output logic [23:0]                m_tdata,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fac_pkg::ADDR_W-1:0] paddr,
	input  logic [fac_pkg::DATA_W-1:0] pwdata,
	output logic [fac_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import fac_pkg::*;

	cfg_t        cfg;
	temp_res_t   tres;
	logic        accept;
	logic        advance;
	logic        valid_s1;
	logic [9:0]  adc_s1;
	logic [31:0] power_s1;
	logic [31:0] now_s1;
	logic [31:0] power_in;
	logic [2:0]  plevel;
	logic [2:0]  level;
	logic        valid_s2;
	logic [7:0]  duty_s2;
	logic [2:0]  level_s2;
	logic [8:0]  celsius_s2;
	logic        over_s2;
	logic        fail_s2;

	fac_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign accept   = s_tvalid & s_tready;
	assign power_in = {16'd0, s_tdata[25:10]} * {16'd0, s_tdata[41:26]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept | (valid_s1 & ~advance);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			adc_s1   <= s_tdata[9:0];
			power_s1 <= power_in;
			now_s1   <= s_tdata[73:42];
		end
	end

	fac_temp u_temp (
		.temp_adc (adc_s1),
		.cfg      (cfg),
		.res      (tres)
	);

	fac_power u_power (
		.clk    (clk),
		.arst_n (arst_n),
		.update (advance),
		.power  (power_s1),
		.now_ms (now_s1),
		.cfg    (cfg),
		.level  (plevel)
	);

	assign level = (plevel > tres.level) ? plevel : tres.level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= advance | (valid_s2 & ~m_tready);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			duty_s2    <= duty_of(level);
			level_s2   <= level;
			celsius_s2 <= tres.celsius;
			over_s2    <= tres.overheat;
			fail_s2    <= tres.sensor_fail;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, fail_s2, over_s2, celsius_s2, level_s2, duty_s2};

endmodule

FILE: design/fac_checker.sv
`timescale 1ns / 1ps
module fac_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);
	import fac_pkg::*;

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed");

	a_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:0] == duty_of(m_tdata[10:8]) && m_tdata[10:8] <= LEVEL_4)
		else $error("duty does not match level");

	a_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[21] |-> m_tdata[20])
		else $error("sensor fail without overheat");

	a_hot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[19:11] >= TEMP_STEP_4 |-> m_tdata[10:8] == LEVEL_4)
		else $error("hot sample below top level");

endmodule

bind fan_aggression_controller_unit fac_checker u_fac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
